// ===== sv/wam_pkg.sv =====
// shared constants, types and command/status structs for the wrapped angle median block
package wam_pkg;

   localparam int WINDOW_DEPTH = 64;
   localparam int ADDR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int ANGLE_W = 13;
   localparam int WRAP_W = ANGLE_W + 1;

   localparam logic [ANGLE_W-1:0] ANG_90 = 13'd1440;
   localparam logic [ANGLE_W-1:0] ANG_180 = 13'd2880;
   localparam logic [ANGLE_W-1:0] ANG_270 = 13'd4320;
   localparam logic [ANGLE_W-1:0] ANG_360 = 13'd5760;

   typedef logic [ANGLE_W-1:0] angle_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic take;      // word accepted on the request channel
      logic ins_rd;    // read neighbor below the insertion point
      logic ins_cmp;   // shift neighbor up or drop the new word in place
      logic med_rd0;   // read lower middle element
      logic med_rd1;   // read upper middle element
      logic med_fin;   // form the median and load the result register
   } dp_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic full;      // held word was dropped, store already held WINDOW_DEPTH samples
      logic shift;     // neighbor is larger, insertion continues downward
      logic last;      // held word closes the window
      logic out_free;  // result register can take a new word
   } dp_stat_type;

endpackage

// ===== sv/wam_req_if.sv =====
// request channel interface: one wind direction sample per word
interface wam_req_if;
   logic valid;
   logic ready;
   logic [wam_pkg::ANGLE_W-1:0] sample_angle;
   logic last_sample;

   modport source (output valid, output sample_angle, output last_sample, input ready);
   modport sink (input valid, input sample_angle, input last_sample, output ready);
endinterface

// ===== sv/wam_rsp_if.sv =====
// response channel interface: one median word per closed window
interface wam_rsp_if;
   logic valid;
   logic ready;
   logic [wam_pkg::ANGLE_W-1:0] median_angle;
   logic overflow;

   modport source (output valid, output median_angle, output overflow, input ready);
   modport sink (input valid, input median_angle, input overflow, output ready);
endinterface

// ===== sv/wam_ctrl.sv =====
// controller state machine: sample intake, insertion steps and median readout
module wam_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  wam_pkg::dp_stat_type stat,
   output wam_pkg::dp_cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_INS_RD  = 3'd1;
   localparam logic [2:0] ST_INS_CMP = 3'd2;
   localparam logic [2:0] ST_MED_RD0 = 3'd3;
   localparam logic [2:0] ST_MED_RD1 = 3'd4;
   localparam logic [2:0] ST_MED_FIN = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_INS_RD;
            end
         end
         ST_INS_RD: begin
            // full store: word was dropped at intake
            if (stat.full) begin
               state_in = stat.last ? ST_MED_RD0 : ST_IDLE;
            end else begin
               cmd.ins_rd = 1'b1;
               state_in = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            cmd.ins_cmp = 1'b1;
            if (stat.shift) begin
               state_in = ST_INS_RD;
            end else begin
               state_in = stat.last ? ST_MED_RD0 : ST_IDLE;
            end
         end
         ST_MED_RD0: begin
            cmd.med_rd0 = 1'b1;
            state_in = ST_MED_RD1;
         end
         ST_MED_RD1: begin
            cmd.med_rd1 = 1'b1;
            state_in = ST_MED_FIN;
         end
         ST_MED_FIN: begin
            if (stat.out_free) begin
               cmd.med_fin = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/wam_datapath.sv =====
// datapath: sorted sample store, window counters, median arithmetic, result register
module wam_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  wam_pkg::dp_cmd_type                 cmd,
   output wam_pkg::dp_stat_type                stat,
   input  logic [wam_pkg::ANGLE_W-1:0]         req_sample_angle,
   input  logic                                req_last_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [wam_pkg::ANGLE_W-1:0]         rsp_median_angle,
   output logic                                rsp_overflow
);

   localparam int AW = wam_pkg::ADDR_W;
   localparam int CW = wam_pkg::CNT_W;
   localparam int WW = wam_pkg::WRAP_W;
   localparam int DEPTH = wam_pkg::WINDOW_DEPTH;
   localparam logic [CW-1:0] ONE_CNT = CW'(1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

   // store kept in ascending unsigned order
   wam_pkg::angle_type sample_mem_ff [DEPTH];

   wam_pkg::angle_type  a_ff;
   logic                last_ff;
   logic                drop_ff;   // held word was dropped at intake
   logic [AW-1:0]       p_ff;
   logic [AW-1:0]       p_in;
   wam_pkg::angle_type  rd_ff;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       outside_ff, outside_in;
   logic [CW-1:0]       low_ff, low_in;    // samples at or below 180 degrees
   logic [CW-1:0]       mid_ff, mid_in;    // samples strictly inside 180..360
   logic                dropped_ff, dropped_in;
   logic signed [WW-1:0] v0_ff;
   logic                rsp_valid_ff;
   wam_pkg::angle_type  median_ff;
   logic                overflow_ff;

   logic                full;
   logic                p_zero;
   logic                shift;
   logic                wrap;
   logic [CW-1:0]       k0, k1;
   logic [AW-1:0]       rd_addr;
   logic                we;
   wam_pkg::angle_type  wdata;
   logic signed [WW-1:0] v1;
   logic signed [WW:0]   pair_sum;
   logic signed [WW-1:0] half;
   logic signed [WW-1:0] med_full;
   logic                in_outside, in_low, in_mid;

   // rank in the wrapped order to place in the unsigned sorted store
   function automatic logic [AW-1:0] map_idx(
      input logic [CW-1:0] k,
      input logic          wr,
      input logic [CW-1:0] clow,
      input logic [CW-1:0] cmid
   );
      logic [CW:0]   span;
      logic [CW-1:0] idx;
      span = {1'b0, cmid} + {1'b0, clow};
      idx = k;
      if (wr) begin
         if (k < cmid) begin
            idx = CW'(clow + k);
         end else if ({1'b0, k} < span) begin
            idx = CW'(k - cmid);
         end
      end
      return idx[AW-1:0];
   endfunction

   function automatic logic signed [WW-1:0] wrap_val(
      input wam_pkg::angle_type v,
      input logic               wr
   );
      logic signed [WW-1:0] s;
      s = $signed({1'b0, v});
      if (wr && (v > wam_pkg::ANG_180) && (v < wam_pkg::ANG_360)) begin
         s = s - $signed({1'b0, wam_pkg::ANG_360});
      end
      return s;
   endfunction

   assign full = (count_ff == DEPTH_CNT);
   assign p_zero = (p_ff == '0);
   assign shift = !p_zero && (rd_ff > a_ff);
   assign wrap = (outside_ff > (count_ff >> 1));
   assign k0 = (count_ff - ONE_CNT) >> 1;
   assign k1 = count_ff >> 1;

   assign stat.full = drop_ff;
   assign stat.shift = shift;
   assign stat.last = last_ff;
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   assign in_outside = (req_sample_angle < wam_pkg::ANG_90) ||
                       (req_sample_angle > wam_pkg::ANG_270);
   assign in_low = (req_sample_angle <= wam_pkg::ANG_180);
   assign in_mid = (req_sample_angle > wam_pkg::ANG_180) &&
                   (req_sample_angle < wam_pkg::ANG_360);

   always_comb begin
      if (cmd.med_rd0) begin
         rd_addr = map_idx(k0, wrap, low_ff, mid_ff);
      end else if (cmd.med_rd1) begin
         rd_addr = map_idx(k1, wrap, low_ff, mid_ff);
      end else begin
         rd_addr = p_ff - 1'b1;
      end
   end

   assign we = cmd.ins_cmp;
   assign wdata = shift ? rd_ff : a_ff;

   // store port: one write, one registered read
   always_ff @(posedge clock) begin
      if (we) begin
         sample_mem_ff[p_ff] <= wdata;
      end
      if (cmd.ins_rd || cmd.med_rd0 || cmd.med_rd1) begin
         rd_ff <= sample_mem_ff[rd_addr];
      end
   end

   // median of the two middle elements, floored, folded back into range
   assign v1 = wrap_val(rd_ff, wrap);
   assign pair_sum = {v0_ff[WW-1], v0_ff} + {v1[WW-1], v1};
   assign half = pair_sum[WW:1];
   assign med_full = half[WW-1] ? (half + $signed({1'b0, wam_pkg::ANG_360})) : half;

   always_comb begin
      p_in = p_ff;
      count_in = count_ff;
      outside_in = outside_ff;
      low_in = low_ff;
      mid_in = mid_ff;
      dropped_in = dropped_ff;
      if (cmd.take) begin
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            p_in = count_ff[AW-1:0];
            count_in = count_ff + ONE_CNT;
            outside_in = outside_ff + (in_outside ? ONE_CNT : '0);
            low_in = low_ff + (in_low ? ONE_CNT : '0);
            mid_in = mid_ff + (in_mid ? ONE_CNT : '0);
         end
      end else if (cmd.ins_cmp && shift) begin
         p_in = p_ff - 1'b1;
      end else if (cmd.med_fin) begin
         count_in = '0;
         outside_in = '0;
         low_in = '0;
         mid_in = '0;
         dropped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         outside_ff <= '0;
         low_ff <= '0;
         mid_ff <= '0;
         dropped_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         outside_ff <= outside_in;
         low_ff <= low_in;
         mid_ff <= mid_in;
         dropped_ff <= dropped_in;
         if (cmd.med_fin) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      if (cmd.take) begin
         a_ff <= req_sample_angle;
         last_ff <= req_last_sample;
         drop_ff <= full;
      end
      if (cmd.med_rd1) begin
         v0_ff <= wrap_val(rd_ff, wrap);
      end
      if (cmd.med_fin) begin
         median_ff <= med_full[wam_pkg::ANGLE_W-1:0];
         overflow_ff <= dropped_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_median_angle = median_ff;
   assign rsp_overflow = overflow_ff;

endmodule

// ===== sv/wrapped_angle_median.sv =====
// top level of the wrapped wind direction median filter
// Collects a window of wind direction samples (1/16 degree, one per request word) and, on
// the word marked last_sample, returns the median on the response channel. Samples are
// kept in ascending order as they arrive: each new sample is placed by insertion, walking
// down the store one neighbor per step (a read, then a compare and write) through its
// one write port and one registered read port, past each stored sample larger than it,
// at most WINDOW_DEPTH - 1; the next sample is taken only after the walk. A dropped
// sample skips the walk. Counters track samples outside 90..270 degrees and the sizes of
// the groups at or below 180 and strictly between 180 and 360 degrees; when more than half
// the window lies outside 90..270, the upper group is treated as negative angles, which
// just rotates the sorted order, so the two middle elements are fetched straight from the
// store. After the last sample is placed, the median step reads the two middle elements
// and loads the result into an output register once it is free; further samples of the
// next window are taken while it waits. Samples arriving with the store full are dropped
// and reported through overflow. There is no clearing pass after reset.
module wrapped_angle_median (
   input  logic       clock,
   input  logic       reset,
   wam_req_if.sink    req_if,
   wam_rsp_if.source  rsp_if
);

   wam_pkg::dp_cmd_type  cmd;
   wam_pkg::dp_stat_type stat;

   // sequencing of intake, insertion and readout
   wam_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // store, counters and median arithmetic
   wam_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_sample_angle (req_if.sample_angle),
      .req_last_sample  (req_if.last_sample),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_median_angle (rsp_if.median_angle),
      .rsp_overflow     (rsp_if.overflow)
   );

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the wrapped angle median filter, with its own median predictor
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // run limits, in clock cycles
   localparam int WATCHDOG_LIMIT = 4000;  // quiet cycles before the run is declared hung
   localparam int RSP_HOLD_CYCLES = 500;  // long receiver hold-off for the back-pressure test
   localparam int TAIL_CYCLES = 200;      // worst insertion walk plus median step, with margin
   localparam int ANGLE_MAX = (1 << wam_pkg::ANGLE_W) - 1;

   // how the samples of one random window are spread around the compass
   typedef enum int {
      MIX_UNIFORM,
      MIX_CLUSTER,
      MIX_FULL_FIELD,
      MIX_EDGES
   } angle_mix_type;

   // one expected median word
   typedef struct packed {
      wam_pkg::angle_type angle;
      logic               overflow;
   } median_word_type;

   logic clock = 1'b0;
   logic reset;

   wam_req_if req_if ();
   wam_rsp_if rsp_if ();

   wrapped_angle_median dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state: the window as the block should hold it
   wam_pkg::angle_type win_store [wam_pkg::WINDOW_DEPTH];
   int                 win_count = 0;
   int                 win_outside = 0;
   bit                 win_dropped = 1'b0;
   median_word_type    expected_medians [$];

   int mismatch_count = 0;

   // idling controls shared by the sender, the receiver and the test tasks
   bit send_idle_on = 1'b0;
   bit rsp_idle_on = 1'b0;
   bit rsp_hold_req = 1'b0;
   bit rsp_holding = 1'b0;

   // median of the stored window, with the wrap of the upper half when most samples
   // point north; samples at or above a full turn are never wrapped
   function automatic wam_pkg::angle_type window_median();
      int vals [wam_pkg::WINDOW_DEPTH];
      int n;
      int key;
      int j;
      int m;
      bit wrap;
      n = win_count;
      wrap = win_outside > n / 2;
      for (int i = 0; i < n; i++) begin
         vals[i] = int'(win_store[i]);
         if (wrap && vals[i] > int'(wam_pkg::ANG_180) && vals[i] < int'(wam_pkg::ANG_360)) begin
            vals[i] = vals[i] - int'(wam_pkg::ANG_360);
         end
      end
      // insertion sort on signed angles
      for (int i = 1; i < n; i++) begin
         key = vals[i];
         j = i;
         while (j > 0 && vals[j - 1] > key) begin
            vals[j] = vals[j - 1];
            j--;
         end
         vals[j] = key;
      end
      if (n % 2 == 1) begin
         m = vals[n / 2];
      end else begin
         // arithmetic shift floors toward minus infinity for negative sums
         m = (vals[n / 2 - 1] + vals[n / 2]) >>> 1;
      end
      if (m < 0) begin
         m = m + int'(wam_pkg::ANG_360);
      end
      return wam_pkg::angle_type'(m);
   endfunction

   // fold one accepted sample word into the predicted window
   function automatic void record_sample(wam_pkg::angle_type angle, logic last);
      median_word_type word;
      if (win_count < wam_pkg::WINDOW_DEPTH) begin
         win_store[win_count] = angle;
         win_count++;
         if (angle < wam_pkg::ANG_90 || angle > wam_pkg::ANG_270) begin
            win_outside++;
         end
      end else begin
         // store full: the sample is lost and the window is flagged
         win_dropped = 1'b1;
      end
      if (last) begin
         word.angle = window_median();
         word.overflow = win_dropped;
         expected_medians.insert(expected_medians.size(), word);
         win_count = 0;
         win_outside = 0;
         win_dropped = 1'b0;
      end
   endfunction

   // monitor: both channels are sampled at the rising edge; request words first so the
   // prediction always stands before the median word it causes
   always @(posedge clock) begin : monitor
      median_word_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            record_sample(req_if.sample_angle, req_if.last_sample);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_medians.size() == 0) begin
               $display("%0t: unexpected median word, angle %0d overflow %0b", $time,
                        rsp_if.median_angle, rsp_if.overflow);
               mismatch_count++;
            end else begin
               want = expected_medians.pop_front();
               if (rsp_if.median_angle !== want.angle) begin
                  $display("%0t: median_angle expected %0d actual %0d", $time,
                           want.angle, rsp_if.median_angle);
                  mismatch_count++;
               end
               if (rsp_if.overflow !== want.overflow) begin
                  $display("%0t: overflow expected %0b actual %0b", $time,
                           want.overflow, rsp_if.overflow);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // watchdog: ends the run when no word moves on either channel for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   // receiver: ready changes on the falling edge; random stall bursts, or one long
   // hold-off on request so the block backs up into the request channel
   initial begin : rsp_driver
      rsp_if.ready <= 1'b0;
      @(negedge clock);
      forever begin
         if (rsp_hold_req) begin
            rsp_holding = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            rsp_hold_req = 1'b0;
            rsp_holding = 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(negedge clock);
      end
   end

   // offer one sample word, called at a falling edge; valid stays high after the word is
   // taken so back-to-back words need no second assignment in the same step
   task automatic send_word(input wam_pkg::angle_type angle, input logic last);
      if (send_idle_on && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.sample_angle <= angle;
      req_if.last_sample <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // stop offering and wait until every predicted median has come back
   task automatic drain_medians();
      req_if.valid <= 1'b0;
      do @(negedge clock); while (expected_medians.size() != 0);
   endtask

   // one random sample of the requested spread
   function automatic wam_pkg::angle_type pick_angle(angle_mix_type mix, int center,
                                                     int spread);
      int v;
      case (mix)
         MIX_UNIFORM: begin
            v = $urandom_range(0, int'(wam_pkg::ANG_360) - 1);
         end
         MIX_CLUSTER: begin
            v = center + int'(wam_pkg::ANG_360) + int'($urandom_range(0, 2 * spread)) - spread;
            v = v % int'(wam_pkg::ANG_360);
         end
         MIX_FULL_FIELD: begin
            v = $urandom_range(0, ANGLE_MAX);
         end
         default: begin
            // just around a range edge or the top of the field
            case ($urandom_range(0, 5))
               0: v = 0;
               1: v = int'(wam_pkg::ANG_90);
               2: v = int'(wam_pkg::ANG_180);
               3: v = int'(wam_pkg::ANG_270);
               4: v = int'(wam_pkg::ANG_360);
               default: v = ANGLE_MAX - 1;
            endcase
            v = v + int'($urandom_range(0, 2)) - 1;
            if (v < 0) begin
               v = 0;
            end
         end
      endcase
      // now and then a stray reading anywhere in the field
      if ($urandom_range(0, 19) == 0) begin
         v = $urandom_range(0, ANGLE_MAX);
      end
      return wam_pkg::angle_type'(v);
   endfunction

   // one window of random size and spread, closed by its last word
   task automatic send_random_window(output int sent);
      int len;
      int center;
      int spread;
      int pick;
      angle_mix_type mix;
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
         len = $urandom_range(1, 12);
      end else if (pick < 19) begin
         len = $urandom_range(13, 40);
      end else begin
         // around and past a full store
         len = $urandom_range(wam_pkg::WINDOW_DEPTH - 4, wam_pkg::WINDOW_DEPTH + 6);
      end
      mix = angle_mix_type'($urandom_range(0, 3));
      // clusters lean north so the wrap is taken often
      center = ($urandom_range(0, 1) == 1) ? 0 :
               $urandom_range(0, int'(wam_pkg::ANG_360) - 1);
      spread = $urandom_range(1, 1200);
      for (int i = 0; i < len; i++) begin
         send_word(pick_angle(mix, center, spread), i == len - 1);
      end
      sent = len;
   endtask

   // single-sample windows at the extremes of the field
   task automatic test_single_samples();
      send_word(wam_pkg::angle_type'(0), 1'b1);
      send_word(wam_pkg::angle_type'(ANGLE_MAX), 1'b1);
      send_word(wam_pkg::ANG_360 - 1'b1, 1'b1);
      send_word(wam_pkg::ANG_360, 1'b1);
      drain_medians();
   endtask

   // windows that take the wrap
   task automatic test_wrap_cases();
      // odd count, median lands on a wrapped sample and is turned back positive
      send_word(wam_pkg::angle_type'(100), 1'b0);
      send_word(wam_pkg::angle_type'(5700), 1'b0);
      send_word(wam_pkg::angle_type'(5600), 1'b1);
      // even count, negative mean is floored before the turn is added back
      send_word(wam_pkg::angle_type'(5740), 1'b0);
      send_word(wam_pkg::angle_type'(10), 1'b1);
      // sample past a full turn counts as outside but is not wrapped
      send_word(wam_pkg::angle_type'(6000), 1'b0);
      send_word(wam_pkg::angle_type'(100), 1'b0);
      send_word(wam_pkg::angle_type'(3000), 1'b1);
      drain_medians();
   endtask

   // samples on and beside the 90, 180 and 270 degree edges, no wrap
   task automatic test_range_edges();
      send_word(wam_pkg::ANG_90 - 1'b1, 1'b0);
      send_word(wam_pkg::ANG_90, 1'b0);
      send_word(wam_pkg::ANG_90 + 1'b1, 1'b0);
      send_word(wam_pkg::ANG_180 - 1'b1, 1'b0);
      send_word(wam_pkg::ANG_180, 1'b0);
      send_word(wam_pkg::ANG_180 + 1'b1, 1'b0);
      send_word(wam_pkg::ANG_270 - 1'b1, 1'b0);
      send_word(wam_pkg::ANG_270, 1'b0);
      send_word(wam_pkg::ANG_270 + 1'b1, 1'b1);
      drain_medians();
   endtask

   // full store: dropped samples, a dropped last word, and the flag clearing afterward
   task automatic test_full_store();
      // full, then the last word itself is dropped
      for (int i = 0; i < wam_pkg::WINDOW_DEPTH; i++) begin
         send_word(pick_angle(MIX_FULL_FIELD, 0, 1), 1'b0);
      end
      send_word(pick_angle(MIX_FULL_FIELD, 0, 1), 1'b1);
      // several drops, north-heavy so the wrap is taken on a full store
      for (int i = 0; i < wam_pkg::WINDOW_DEPTH + 3; i++) begin
         send_word(pick_angle(MIX_CLUSTER, 0, 900), i == wam_pkg::WINDOW_DEPTH + 2);
      end
      // exactly full with the last word stored, no drop
      for (int i = 0; i < wam_pkg::WINDOW_DEPTH; i++) begin
         send_word(pick_angle(MIX_UNIFORM, 0, 1), i == wam_pkg::WINDOW_DEPTH - 1);
      end
      // a small window must come back without the flag
      send_word(wam_pkg::angle_type'(100), 1'b0);
      send_word(wam_pkg::angle_type'(200), 1'b1);
      drain_medians();
   endtask

   // receiver holds off while the sender keeps going, so the block fills and stalls
   task automatic test_result_backpressure();
      rsp_hold_req = 1'b1;
      while (!rsp_holding) @(negedge clock);
      for (int w = 0; w < 4; w++) begin
         for (int i = 0; i < 5; i++) begin
            send_word(pick_angle(MIX_UNIFORM, 0, 1), i == 4);
         end
      end
      drain_medians();
   endtask

   // random windows until the word budget is spent
   task automatic test_random_windows(input int budget, input bit with_idle);
      int total;
      int sent;
      send_idle_on = with_idle;
      rsp_idle_on = with_idle;
      total = 0;
      while (total < budget) begin
         send_random_window(sent);
         total = total + sent;
      end
      drain_medians();
   endtask

   initial begin
      req_if.valid <= 1'b0;
      req_if.sample_angle <= '0;
      req_if.last_sample <= 1'b0;
      reset <= 1'b1;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      test_single_samples();
      test_wrap_cases();
      test_range_edges();

      send_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      test_full_store();

      send_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      test_result_backpressure();

      test_random_windows(400, 1'b1);
      // closing stretch at full rate on both sides
      test_random_windows(100, 1'b0);

      // let any stray word show up before the verdict
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && expected_medians.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
